### rtl/core/mart_pkg.sv
// Shared types and constants of the magnetic angle rotation tracker.
package mart_pkg;

  localparam int ANGLE_BITS = 12;
  localparam int DELTA_W    = ANGLE_BITS + 1;
  localparam int ANGLE_FULL = 1 << ANGLE_BITS;
  localparam int ANGLE_HALF = ANGLE_FULL / 2;
  localparam int POS_W      = 32;
  localparam int TIME_W     = 32;
  localparam int STEP_W     = 12;
  localparam int DEB_W      = 16;
  localparam int MASK_W     = 8;
  localparam int IDX_W      = 3;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [STEP_W-1:0] MAX_STEP_RST = STEP_W'(50);
  localparam logic [STEP_W-1:0] MIN_STEP_RST = STEP_W'(3);
  localparam logic [DEB_W-1:0]  DEBOUNCE_RST = DEB_W'(150);
  localparam logic [MASK_W-1:0] REV_MASK_RST = '0;

  typedef enum logic [2:0] {
    ST_MOVED = 3'd0,
    ST_DISC  = 3'd1,
    ST_FIRST = 3'd2,
    ST_JUMP  = 3'd3,
    ST_SMALL = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_STEP = 4'd0,
    CFG_MIN_STEP = 4'd1,
    CFG_DEBOUNCE = 4'd2,
    CFG_REV_MASK = 4'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [ANGLE_BITS-1:0] last_angle;
    logic [POS_W-1:0]      position;
    logic [POS_W-1:0]      reported;
    logic [TIME_W-1:0]     event_time;
  } state_t;

  typedef struct packed {
    status_e                    status;
    logic signed [DELTA_W-1:0]  delta;
    state_t                     state;
  } calc_t;

  typedef struct packed {
    logic rotation_event;
    logic clockwise;
  } event_t;

endpackage

### rtl/core/mart_state_mem.sv
// Per-encoder state memory with valid bits and write-to-read forwarding.
module mart_state_mem import mart_pkg::*; #(
  parameter int NUM_ENCODERS = 8,
  localparam int AddrW = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output state_t           rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  state_t           wr_data_i
);

  state_t                  mem_q [NUM_ENCODERS];
  logic [NUM_ENCODERS-1:0] vld_q;
  state_t                  rd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_data_q <= wr_data_i;
      end else if (vld_q[rd_addr_i]) begin
        rd_data_q <= mem_q[rd_addr_i];
      end else begin
        rd_data_q <= '0;
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/core/mart_calc.sv
// Angle unwrap, step limits and position update for one item.
module mart_calc import mart_pkg::*; (
  input  logic                  in_range_i,
  input  logic                  connected_i,
  input  logic                  reverse_i,
  input  logic [ANGLE_BITS-1:0] median_i,
  input  logic [STEP_W-1:0]     max_step_i,
  input  logic [STEP_W-1:0]     min_step_i,
  input  state_t                state_i,
  output calc_t                 calc_o
);

  localparam logic signed [DELTA_W:0] HalfS = (DELTA_W + 1)'(ANGLE_HALF);
  localparam logic signed [DELTA_W:0] FullS = (DELTA_W + 1)'(ANGLE_FULL);

  logic signed [DELTA_W:0]   diff;
  logic signed [DELTA_W:0]   unw;
  logic signed [DELTA_W:0]   mag_w;
  logic [ANGLE_BITS-1:0]     mag;
  logic signed [DELTA_W-1:0] delta;
  logic [POS_W-1:0]          delta_ext;
  logic [POS_W-1:0]          pos_next;

  assign diff = $signed({2'b00, median_i}) - $signed({2'b00, state_i.last_angle});

  always_comb begin
    if (diff > HalfS) begin
      unw = diff - FullS;
    end else if (diff < -HalfS) begin
      unw = diff + FullS;
    end else begin
      unw = diff;
    end
  end

  assign mag_w     = (unw < 0) ? -unw : unw;
  assign mag       = mag_w[ANGLE_BITS-1:0];
  assign delta     = unw[DELTA_W-1:0];
  assign delta_ext = {{(POS_W - DELTA_W){delta[DELTA_W-1]}}, delta};
  assign pos_next  = reverse_i ? (state_i.position - delta_ext)
                               : (state_i.position + delta_ext);

  always_comb begin
    calc_o.status = ST_DISC;
    calc_o.delta  = '0;
    calc_o.state  = state_i;
    if (!in_range_i) begin
      calc_o.state.position = '0;
    end else if (connected_i) begin
      if (state_i.last_angle == '0) begin
        calc_o.status           = ST_FIRST;
        calc_o.state.last_angle = median_i;
      end else begin
        calc_o.delta = delta;
        if (mag > max_step_i) begin
          calc_o.status = ST_JUMP;
        end else if (mag < min_step_i) begin
          calc_o.status = ST_SMALL;
        end else begin
          calc_o.status           = ST_MOVED;
          calc_o.state.last_angle = median_i;
          calc_o.state.position   = pos_next;
        end
      end
    end
  end

endmodule

### rtl/core/mart_event.sv
// Debounced rotation event check against the last reported position.
module mart_event import mart_pkg::*; (
  input  logic              in_range_i,
  input  state_t            state_i,
  input  logic [TIME_W-1:0] time_i,
  input  logic [DEB_W-1:0]  debounce_i,
  output event_t            event_o,
  output state_t            state_o
);

  logic [TIME_W-1:0] elapsed;
  logic              fire;

  assign elapsed = time_i - state_i.event_time;
  assign fire    = in_range_i && (state_i.position != state_i.reported) &&
                   (elapsed > {{(TIME_W - DEB_W){1'b0}}, debounce_i});

  always_comb begin
    event_o.rotation_event = fire;
    event_o.clockwise      = fire &&
                             ($signed(state_i.position) > $signed(state_i.reported));
    state_o = state_i;
    if (fire) begin
      state_o.reported   = state_i.position;
      state_o.event_time = time_i;
    end
  end

endmodule

### rtl/core/magnetic_angle_rotation_tracker_unit.sv
// Top level of the magnetic angle rotation tracker.
// Each accepted beat passes through stages e1 and e2 to the output register.
// Beats for different encoders are accepted every cycle while the output
// does not stall; a beat waits until an older beat of its encoder reaches
// the output register, where its state memory entry, read at acceptance,
// is written back. State entries carry valid bits that reset clears at
// once, so the block is ready right after reset.
module magnetic_angle_rotation_tracker_unit import mart_pkg::*; #(
  parameter int NUM_ENCODERS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [IDX_W-1:0]             encoder_index_i,
  input  logic [ANGLE_BITS-1:0]        sample_a_i,
  input  logic [ANGLE_BITS-1:0]        sample_b_i,
  input  logic [ANGLE_BITS-1:0]        sample_c_i,
  input  logic                         sensor_connected_i,
  input  logic [TIME_W-1:0]            time_ms_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [IDX_W-1:0]             encoder_id_o,
  output logic [2:0]                   status_o,
  output logic signed [DELTA_W-1:0]    angle_delta_o,
  output logic signed [POS_W-1:0]      position_o,
  output logic                         rotation_event_o,
  output logic                         clockwise_o
);

  localparam int AddrW = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;

  logic [STEP_W-1:0] max_step_q, min_step_q;
  logic [DEB_W-1:0]  debounce_q;
  logic [MASK_W-1:0] rev_mask_q;

  logic                  e1_vld_q, e1_inr_q, e1_conn_q;
  logic [IDX_W-1:0]      e1_idx_q;
  logic [ANGLE_BITS-1:0] e1_med_q;
  logic [TIME_W-1:0]     e1_time_q;

  logic              e2_vld_q, e2_inr_q;
  logic [IDX_W-1:0]  e2_idx_q;
  calc_t             e2_calc_q;
  logic [TIME_W-1:0] e2_time_q;

  logic                      out_vld_q, out_ev_q, out_cw_q;
  logic [IDX_W-1:0]          out_id_q;
  status_e                   out_status_q;
  logic signed [DELTA_W-1:0] out_delta_q;
  logic [POS_W-1:0]          out_pos_q;

  logic                  out_adv, e2_adv, e2_free, e1_adv, e1_free;
  logic                  hazard, in_acc, in_range;
  logic [ANGLE_BITS-1:0] lo_ab, hi_ab, med;
  logic [AddrW+IDX_W-1:0] rd_ext, wr_ext;
  state_t                rd_state, wr_state;
  calc_t                 calc;
  event_t                evt;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_step_q <= MAX_STEP_RST;
      min_step_q <= MIN_STEP_RST;
      debounce_q <= DEBOUNCE_RST;
      rev_mask_q <= REV_MASK_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MAX_STEP: max_step_q <= cfg_data_i[STEP_W-1:0];
        CFG_MIN_STEP: min_step_q <= cfg_data_i[STEP_W-1:0];
        CFG_DEBOUNCE: debounce_q <= cfg_data_i[DEB_W-1:0];
        CFG_REV_MASK: rev_mask_q <= cfg_data_i[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_adv = !out_vld_q || !out_stall_i;
  assign e2_adv  = e2_vld_q && out_adv;
  assign e2_free = !e2_vld_q || out_adv;
  assign e1_adv  = e1_vld_q && e2_free;
  assign e1_free = !e1_vld_q || e2_free;

  // An item must not read an entry that an older item still has to write.
  assign hazard = (e1_vld_q && (e1_idx_q == encoder_index_i)) ||
                  (e2_vld_q && (e2_idx_q == encoder_index_i) && !e2_adv);

  assign in_stall_o = !e1_free || hazard;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_range   = 32'(encoder_index_i) < 32'(NUM_ENCODERS);

  assign lo_ab = (sample_a_i < sample_b_i) ? sample_a_i : sample_b_i;
  assign hi_ab = (sample_a_i < sample_b_i) ? sample_b_i : sample_a_i;
  always_comb begin
    if (sample_c_i < lo_ab) begin
      med = lo_ab;
    end else if (sample_c_i > hi_ab) begin
      med = hi_ab;
    end else begin
      med = sample_c_i;
    end
  end

  assign rd_ext = {{AddrW{1'b0}}, encoder_index_i};
  assign wr_ext = {{AddrW{1'b0}}, e2_idx_q};

  mart_state_mem #(
    .NUM_ENCODERS(NUM_ENCODERS)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc && in_range),
    .rd_addr_i (rd_ext[AddrW-1:0]),
    .rd_data_o (rd_state),
    .wr_en_i   (e2_adv && e2_inr_q),
    .wr_addr_i (wr_ext[AddrW-1:0]),
    .wr_data_i (wr_state)
  );

  mart_calc u_calc (
    .in_range_i  (e1_inr_q),
    .connected_i (e1_conn_q),
    .reverse_i   (rev_mask_q[e1_idx_q]),
    .median_i    (e1_med_q),
    .max_step_i  (max_step_q),
    .min_step_i  (min_step_q),
    .state_i     (rd_state),
    .calc_o      (calc)
  );

  mart_event u_event (
    .in_range_i (e2_inr_q),
    .state_i    (e2_calc_q.state),
    .time_i     (e2_time_q),
    .debounce_i (debounce_q),
    .event_o    (evt),
    .state_o    (wr_state)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_vld_q  <= 1'b0;
      e2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (e1_free) begin
        e1_vld_q <= in_acc;
      end
      if (e2_free) begin
        e2_vld_q <= e1_adv;
      end
      if (out_adv) begin
        out_vld_q <= e2_adv;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      e1_idx_q  <= encoder_index_i;
      e1_inr_q  <= in_range;
      e1_conn_q <= sensor_connected_i;
      e1_med_q  <= med;
      e1_time_q <= time_ms_i;
    end
    if (e1_adv) begin
      e2_idx_q  <= e1_idx_q;
      e2_inr_q  <= e1_inr_q;
      e2_calc_q <= calc;
      e2_time_q <= e1_time_q;
    end
    if (e2_adv) begin
      out_id_q     <= e2_idx_q;
      out_status_q <= e2_calc_q.status;
      out_delta_q  <= e2_calc_q.delta;
      out_pos_q    <= e2_calc_q.state.position;
      out_ev_q     <= evt.rotation_event;
      out_cw_q     <= evt.clockwise;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign encoder_id_o     = out_id_q;
  assign status_o         = out_status_q;
  assign angle_delta_o    = out_delta_q;
  assign position_o       = $signed(out_pos_q);
  assign rotation_event_o = out_ev_q;
  assign clockwise_o      = out_cw_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> e1_vld_q)
    else $error("Accepted beat did not enter the first stage.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_DISC || status_o == ST_FIRST)) |->
      (angle_delta_o == '0))
    else $error("Result without an angle compare carries a nonzero delta.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && clockwise_o) |-> rotation_event_o)
    else $error("Clockwise flag set without a rotation event.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (e1_vld_q && e2_vld_q && !$past(e2_adv)) |-> (e1_idx_q != e2_idx_q))
    else $error("Two beats of one encoder overlap in the update pipeline.");
`endif

endmodule

### tb/tb_magnetic_angle_rotation_tracker_unit.sv
// Self-checking testbench of the magnetic angle rotation tracker with a per-encoder tracking model.
module tb_magnetic_angle_rotation_tracker_unit;
  import mart_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_ENC = 8;

  typedef struct packed {
    logic [IDX_W-1:0]      enc;
    logic [ANGLE_BITS-1:0] sa;
    logic [ANGLE_BITS-1:0] sb;
    logic [ANGLE_BITS-1:0] sc;
    logic                  conn;
    logic [TIME_W-1:0]     stamp;
  } sample_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0]          id;
    status_e                   status;
    logic signed [DELTA_W-1:0] delta;
    logic signed [POS_W-1:0]   pos;
    logic                      ev;
    logic                      cw;
  } track_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic                  in_valid = 1'b0;
  logic                  in_stall_o;
  logic [IDX_W-1:0]      encoder_index = '0;
  logic [ANGLE_BITS-1:0] sample_a = '0;
  logic [ANGLE_BITS-1:0] sample_b = '0;
  logic [ANGLE_BITS-1:0] sample_c = '0;
  logic                  sensor_connected = 1'b0;
  logic [TIME_W-1:0]     time_ms = '0;

  logic                      out_valid_o;
  logic                      out_stall = 1'b1;
  logic [IDX_W-1:0]          encoder_id_o;
  logic [2:0]                status_o;
  logic signed [DELTA_W-1:0] angle_delta_o;
  logic signed [POS_W-1:0]   position_o;
  logic                      rotation_event_o;
  logic                      clockwise_o;

  magnetic_angle_rotation_tracker_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall_o),
    .encoder_index_i    (encoder_index),
    .sample_a_i         (sample_a),
    .sample_b_i         (sample_b),
    .sample_c_i         (sample_c),
    .sensor_connected_i (sensor_connected),
    .time_ms_i          (time_ms),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall),
    .encoder_id_o       (encoder_id_o),
    .status_o           (status_o),
    .angle_delta_o      (angle_delta_o),
    .position_o         (position_o),
    .rotation_event_o   (rotation_event_o),
    .clockwise_o        (clockwise_o)
  );

  logic [STEP_W-1:0] max_step_r = MAX_STEP_RST;
  logic [STEP_W-1:0] min_step_r = MIN_STEP_RST;
  logic [DEB_W-1:0]  debounce_r = DEBOUNCE_RST;
  logic [MASK_W-1:0] rev_mask_r = REV_MASK_RST;

  logic [ANGLE_BITS-1:0] last_angle_q [NUM_ENC] = '{default: '0};
  logic [POS_W-1:0]      position_q   [NUM_ENC] = '{default: '0};
  logic [POS_W-1:0]      reported_q   [NUM_ENC] = '{default: '0};
  logic [TIME_W-1:0]     event_time_q [NUM_ENC] = '{default: '0};

  sample_beat_t  sample_beats [$];
  track_result_t predicted_results [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int holds_asked = 0;
  int holds_served = 0;
  int hold_left = 0;
  int errors = 0;

  logic [ANGLE_BITS-1:0] gen_angle [NUM_ENC] = '{default: '0};
  logic [TIME_W-1:0]     gen_time = 32'd1000;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [ANGLE_BITS-1:0] median3(logic [ANGLE_BITS-1:0] a,
                                                    logic [ANGLE_BITS-1:0] b,
                                                    logic [ANGLE_BITS-1:0] c);
    if ((a <= b && b <= c) || (c <= b && b <= a)) return b;
    if ((b <= a && a <= c) || (c <= a && a <= b)) return a;
    return c;
  endfunction

  function automatic track_result_t track_predict(sample_beat_t beat);
    track_result_t     res;
    logic [ANGLE_BITS-1:0] cur;
    int                d;
    int                mag;
    logic [POS_W-1:0]  pos;
    logic [TIME_W-1:0] elapsed;
    res.id = beat.enc;
    res.ev = 1'b0;
    res.cw = 1'b0;
    d = 0;
    if (!beat.conn) begin
      res.status = ST_DISC;
    end else begin
      cur = median3(beat.sa, beat.sb, beat.sc);
      if (last_angle_q[beat.enc] == '0) begin
        last_angle_q[beat.enc] = cur;
        res.status = ST_FIRST;
      end else begin
        d = int'(cur) - int'(last_angle_q[beat.enc]);
        if (d > ANGLE_HALF) d -= ANGLE_FULL;
        else if (-d > ANGLE_HALF) d += ANGLE_FULL;
        mag = (d < 0) ? -d : d;
        if (mag > int'(max_step_r)) begin
          res.status = ST_JUMP;
        end else if (mag < int'(min_step_r)) begin
          res.status = ST_SMALL;
        end else begin
          if (rev_mask_r[beat.enc]) position_q[beat.enc] -= 32'(d);
          else position_q[beat.enc] += 32'(d);
          last_angle_q[beat.enc] = cur;
          res.status = ST_MOVED;
        end
      end
    end
    res.delta = DELTA_W'(d);
    pos = position_q[beat.enc];
    elapsed = beat.stamp - event_time_q[beat.enc];
    if (pos != reported_q[beat.enc] && elapsed > 32'(debounce_r)) begin
      res.ev = 1'b1;
      res.cw = $signed(pos) > $signed(reported_q[beat.enc]);
      reported_q[beat.enc] = pos;
      event_time_q[beat.enc] = beat.stamp;
    end
    res.pos = pos;
    return res;
  endfunction

  always @(posedge clk_i) begin : drive_beats
    logic         offer;
    sample_beat_t beat;
    if (rst_ni) begin
      offer = in_valid;
      if (in_valid && !in_stall_o) begin
        predicted_results.push_back(track_predict({encoder_index, sample_a, sample_b,
                                                   sample_c, sensor_connected, time_ms}));
        offer = 1'b0;
      end
      if (!offer && sample_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        beat = sample_beats.pop_front();
        encoder_index    <= beat.enc;
        sample_a         <= beat.sa;
        sample_b         <= beat.sb;
        sample_c         <= beat.sc;
        sensor_connected <= beat.conn;
        time_ms          <= beat.stamp;
        offer = 1'b1;
      end
      in_valid <= offer;
    end
  end

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      out_stall <= 1'b1;
      hold_left <= 150;
      holds_served <= holds_served + 1;
    end else begin
      out_stall <= $urandom_range(0, 99) < recv_idle_pct;
    end
  end

  always @(posedge clk_i) begin : check_results
    track_result_t got;
    track_result_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      got = {encoder_id_o, status_e'(status_o), angle_delta_o, position_o,
             rotation_event_o, clockwise_o};
      if (predicted_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected beat: id %0d status %0d delta %0d pos %0d ev %0b cw %0b",
                   got.id, got.status, got.delta, got.pos, got.ev, got.cw);
      end else begin
        want = predicted_results.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch: expected id %0d status %0d delta %0d pos %0d ev %0b cw %0b,",
                      " got id %0d status %0d delta %0d pos %0d ev %0b cw %0b"},
                     want.id, want.status, want.delta, want.pos, want.ev, want.cw,
                     got.id, got.status, got.delta, got.pos, got.ev, got.cw);
        end
      end
    end
  end

  task automatic push_beat(int enc, int a, int b, int c, bit conn, logic [TIME_W-1:0] stamp);
    sample_beats.push_back({IDX_W'(enc), 12'(a), 12'(b), 12'(c), conn, stamp});
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_MAX_STEP: max_step_r = data[STEP_W-1:0];
      CFG_MIN_STEP: min_step_r = data[STEP_W-1:0];
      CFG_DEBOUNCE: debounce_r = data[DEB_W-1:0];
      CFG_REV_MASK: rev_mask_r = data[MASK_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(int max_step, int min_step, int debounce, int rev_mask);
    @(posedge clk_i);
    write_reg(CFG_MAX_STEP, CFG_DATA_W'(max_step));
    write_reg(CFG_MIN_STEP, CFG_DATA_W'(min_step));
    write_reg(CFG_DEBOUNCE, CFG_DATA_W'(debounce));
    write_reg(CFG_REV_MASK, CFG_DATA_W'(rev_mask));
    cfg_valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (sample_beats.size() != 0 || in_valid || predicted_results.size() != 0);
  endtask

  // Most beats follow a slowly turning shaft with jitter; beats with an even roll carry one outlier reading.
  task automatic queue_tracking_beats(int count, int reach);
    sample_beat_t          beat;
    int                    roll;
    int                    step;
    logic [ANGLE_BITS-1:0] reading [3];
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      beat.enc = IDX_W'($urandom_range(0, NUM_ENC - 1));
      gen_time += (roll % 9 == 0) ? $urandom_range(0, 100000) : $urandom_range(0, 300);
      beat.stamp = gen_time;
      if (roll < 8) begin
        beat.sa = ANGLE_BITS'($urandom);
        beat.sb = ANGLE_BITS'($urandom);
        beat.sc = ANGLE_BITS'($urandom);
        beat.conn = 1'($urandom);
        beat.stamp = $urandom;
      end else begin
        step = (roll < 16) ? $urandom_range(0, 4095) : $urandom_range(0, 2 * reach) - reach;
        gen_angle[beat.enc] = gen_angle[beat.enc] + ANGLE_BITS'(step);
        for (int k = 0; k < 3; k++)
          reading[k] = gen_angle[beat.enc] + ANGLE_BITS'($urandom_range(0, 2)) - 12'd1;
        if (roll % 2 == 0) reading[$urandom_range(0, 2)] = ANGLE_BITS'($urandom);
        beat.sa = reading[0];
        beat.sb = reading[1];
        beat.sc = reading[2];
        beat.conn = !(roll >= 8 && roll < 12);
      end
      sample_beats.push_back(beat);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 34;
    recv_idle_pct = 68;
    push_beat(0, 100, 200, 150, 1, 32'd1000);
    push_beat(0, 160, 160, 4095, 1, 32'd1200);
    push_beat(0, 170, 0, 170, 1, 32'd1300);
    push_beat(0, 171, 171, 171, 1, 32'd1350);
    push_beat(0, 4095, 175, 175, 1, 32'd1351);
    push_beat(0, 300, 300, 300, 0, 32'd1600);
    push_beat(0, 275, 275, 275, 1, 32'd1700);
    push_beat(1, 0, 0, 5, 1, 32'd1800);
    push_beat(1, 10, 10, 10, 1, 32'd1900);
    push_beat(2, 4090, 4090, 4090, 1, 32'd2000);
    push_beat(2, 5, 5, 5, 1, 32'd2100);
    push_beat(2, 4094, 4094, 4094, 1, 32'd2300);
    push_beat(0, 140, 140, 140, 1, 32'd2500);
    push_beat(3, 4095, 4095, 4095, 1, 32'd2600);
    push_beat(3, 0, 4095, 2048, 1, 32'd2700);
    push_beat(2, 4050, 4050, 4050, 1, 32'hFFFF_FFF0);
    push_beat(2, 4020, 4020, 4020, 1, 32'h0000_0080);
    push_beat(2, 4000, 4000, 4000, 1, 32'h0000_00A0);
    push_beat(3, 4090, 1, 4091, 1, 32'h0000_0200);
    push_beat(5, 2048, 2048, 2048, 0, 32'h0000_0300);
    wait_drained();

    apply_settings(2048, 0, 0, 8'hFF);
    push_beat(4, 100, 100, 100, 1, 32'd10);
    push_beat(4, 2148, 2148, 2148, 1, 32'd20);
    push_beat(4, 100, 100, 100, 1, 32'd30);
    push_beat(4, 100, 100, 100, 1, 32'd40);
    queue_tracking_beats(200, 300);
    wait_drained();

    send_idle_pct = 68;
    recv_idle_pct = 34;
    gen_time = 32'hFFF0_0000;
    apply_settings(300, 5, 65535, 8'hA5);
    queue_tracking_beats(200, 320);
    wait_drained();

    apply_settings(0, 2048, 1000, 8'h5A);
    queue_tracking_beats(60, 10);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_settings(120, 3, 150, 8'h0F);
    holds_asked = holds_asked + 1;
    queue_tracking_beats(100, 130);
    wait_drained();
    queue_tracking_beats(140, 130);
    wait_drained();

    repeat (20) @(posedge clk_i);
    errors += predicted_results.size();
    if (errors == 0) begin
      $display("PASS magnetic_angle_rotation_tracker_unit");
    end else begin
      $display("FAIL magnetic_angle_rotation_tracker_unit");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL magnetic_angle_rotation_tracker_unit");
    $finish;
  end

endmodule

### filelist.f
rtl/core/mart_pkg.sv
rtl/core/mart_state_mem.sv
rtl/core/mart_calc.sv
rtl/core/mart_event.sv
rtl/core/magnetic_angle_rotation_tracker_unit.sv
tb/tb_magnetic_angle_rotation_tracker_unit.sv
